FILE: rtl/utf8_to_utf16_decoder_top_assert.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define UTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies.
package utd_pkg;

  localparam int UTD_QUEUE_DEPTH = 4;

  localparam logic [7:0]  UTD_ASCII_LIMIT  = 8'h80;
  localparam logic [20:0] UTD_MIN_2BYTE    = 21'h000080;
  localparam logic [20:0] UTD_MIN_3BYTE    = 21'h000800;
  localparam logic [20:0] UTD_MIN_4BYTE    = 21'h010000;
  localparam logic [20:0] UTD_MAX_CP       = 21'h10FFFF;
  localparam logic [20:0] UTD_SURR_FIRST   = 21'h00D800;
  localparam logic [20:0] UTD_SURR_LAST    = 21'h00DFFF;
  localparam logic [20:0] UTD_BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] UTD_NARROW_MAX   = 21'h0000FF;
  localparam logic [15:0] UTD_HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] UTD_LO_SURR_BASE = 16'hDC00;
  localparam logic [9:0]  UTD_LO_MASK      = 10'h3FF;

  localparam logic [1:0] UTD_SEQ_NONE = 2'd0;
  localparam logic [1:0] UTD_SEQ_TWO  = 2'd1;
  localparam logic [1:0] UTD_SEQ_THREE = 2'd2;
  localparam logic [1:0] UTD_SEQ_FOUR = 2'd3;

  // One decoded code point, or an invalid string end, on its way to the back end.
  typedef struct packed {
    logic [20:0] cp;
    logic        fin;
    logic        bad;
    logic        narrow;
  } utd_entry_t;

endpackage

FILE: rtl/utd_front.sv
// Front end: validates UTF-8 bytes and assembles code points.
// Depends on utd_pkg.
`include "utf8_to_utf16_decoder_top_assert.svh"

module utd_front
  import utd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_string_end,
  output logic       wr_en,
  output utd_entry_t wr_entry
);

  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  seq_r, seq_nxt;
  logic [20:0] part_r, part_nxt;
  logic        err_r, err_nxt;
  logic        narrow_r, narrow_nxt;

  logic        err;
  logic        emit;
  logic [20:0] cp_out;
  logic [20:0] part_cat;
  logic [20:0] min_cp;
  logic        narrow_upd;

  assign part_cat = {part_r[14:0], in_byte[5:0]};

  always_comb begin
    unique case (seq_r)
      UTD_SEQ_TWO:   min_cp = UTD_MIN_2BYTE;
      UTD_SEQ_THREE: min_cp = UTD_MIN_3BYTE;
      default:       min_cp = UTD_MIN_4BYTE;
    endcase
  end

  always_comb begin
    err        = err_r;
    emit       = 1'b0;
    cp_out     = '0;
    pend_nxt   = pend_r;
    seq_nxt    = seq_r;
    part_nxt   = part_r;
    err_nxt    = err_r;
    narrow_nxt = narrow_r;
    wr_en      = 1'b0;
    wr_entry   = '0;

    if (!err_r) begin
      if (pend_r == 2'd0) begin
        if (in_byte < UTD_ASCII_LIMIT) begin
          emit   = 1'b1;
          cp_out = {13'd0, in_byte};
        end else if (in_byte[7:5] == 3'b110) begin
          seq_nxt  = UTD_SEQ_TWO;
          pend_nxt = 2'd1;
          part_nxt = {16'd0, in_byte[4:0]};
        end else if (in_byte[7:4] == 4'b1110) begin
          seq_nxt  = UTD_SEQ_THREE;
          pend_nxt = 2'd2;
          part_nxt = {17'd0, in_byte[3:0]};
        end else if (in_byte[7:3] == 5'b11110) begin
          seq_nxt  = UTD_SEQ_FOUR;
          pend_nxt = 2'd3;
          part_nxt = {18'd0, in_byte[2:0]};
        end else begin
          err = 1'b1;
        end
      end else if (in_byte[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        pend_nxt = pend_r - 2'd1;
        part_nxt = part_cat;
        if (pend_nxt == 2'd0) begin
          if (part_cat < min_cp || part_cat > UTD_MAX_CP ||
              (part_cat >= UTD_SURR_FIRST && part_cat <= UTD_SURR_LAST)) begin
            err = 1'b1;
          end else begin
            emit   = 1'b1;
            cp_out = part_cat;
          end
          seq_nxt  = UTD_SEQ_NONE;
          part_nxt = '0;
        end
      end
      if (!err && in_string_end && pend_nxt != 2'd0) begin
        err = 1'b1;
      end
    end

    narrow_upd = narrow_r & ~(emit & (cp_out > UTD_NARROW_MAX));

    if (err) begin
      pend_nxt = 2'd0;
      seq_nxt  = UTD_SEQ_NONE;
      part_nxt = '0;
      if (in_string_end) begin
        wr_en        = 1'b1;
        wr_entry.fin = 1'b1;
        wr_entry.bad = 1'b1;
        err_nxt      = 1'b0;
        narrow_nxt   = 1'b1;
      end else begin
        err_nxt = 1'b1;
      end
    end else begin
      wr_en           = emit;
      wr_entry.cp     = cp_out;
      wr_entry.fin    = in_string_end;
      wr_entry.narrow = in_string_end & narrow_upd;
      narrow_nxt      = in_string_end ? 1'b1 : narrow_upd;
    end

    if (!accept) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 2'd0;
      seq_r    <= UTD_SEQ_NONE;
      part_r   <= '0;
      err_r    <= 1'b0;
      narrow_r <= 1'b1;
    end else if (accept) begin
      pend_r   <= pend_nxt;
      seq_r    <= seq_nxt;
      part_r   <= part_nxt;
      err_r    <= err_nxt;
      narrow_r <= narrow_nxt;
    end
  end

  `UTD_ASSERT_NEXT(a_end_clears, accept && in_string_end,
                   !err_r && pend_r == 2'd0 && narrow_r, "string end left state behind")
  `UTD_ASSERT_NOW(a_idle_seq, pend_r == 2'd0, part_r == '0 && seq_r == UTD_SEQ_NONE,
                  "partial code held with no pending bytes")

endmodule

FILE: rtl/utd_fifo.sv
// Flop-based queue of decoded entries between front and back end.
// Depends on utd_pkg.
`include "utf8_to_utf16_decoder_top_assert.svh"

module utd_fifo
  import utd_pkg::*;
#(
  parameter int DEPTH = UTD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  utd_entry_t wr_entry,
  input  logic       rd_en,
  output utd_entry_t rd_entry,
  output logic       full,
  output logic       empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utd_entry_t    mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= wrap_inc(wptr_r);
      end
      if (rd_en) begin
        rptr_r <= wrap_inc(rptr_r);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `UTD_ASSERT_NOW(a_no_overflow, wr_en, !full, "write into full queue")
  `UTD_ASSERT_NOW(a_no_underflow, rd_en, !empty, "read from empty queue")

endmodule

FILE: rtl/utd_back.sv
// Back end: turns queued code points into UTF-16 result beats.
// Depends on utd_pkg.
`include "utf8_to_utf16_decoder_top_assert.svh"

module utd_back
  import utd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  utd_entry_t  head,
  input  logic        head_valid,
  output logic        rd_en,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [15:0] out_code_unit,
  output logic        out_final_unit,
  output logic        out_invalid,
  output logic        out_all_narrow
);

  logic        phase_r;
  logic        pair;
  logic [20:0] offs;
  logic [15:0] hi_unit, lo_unit;
  logic        beat;

  assign pair    = !head.bad && (head.cp > UTD_BMP_MAX);
  assign offs    = head.cp - UTD_MIN_4BYTE;
  assign hi_unit = UTD_HI_SURR_BASE + {6'd0, offs[19:10]};
  assign lo_unit = UTD_LO_SURR_BASE + {6'd0, offs[9:0] & UTD_LO_MASK};

  assign out_empty = !head_valid;
  assign beat      = out_pop && head_valid;
  assign rd_en     = beat && (!pair || phase_r);

  always_comb begin
    if (pair && !phase_r) begin
      out_code_unit  = hi_unit;
      out_final_unit = 1'b0;
      out_invalid    = 1'b0;
      out_all_narrow = 1'b0;
    end else begin
      out_code_unit  = pair ? lo_unit : head.cp[15:0];
      out_final_unit = head.fin;
      out_invalid    = head.bad;
      out_all_narrow = head.narrow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (beat) begin
      phase_r <= pair && !phase_r;
    end
  end

  `UTD_ASSERT_NOW(a_phase_pair, phase_r, head_valid && pair,
                  "second half pending without a pair at the head")

endmodule

FILE: rtl/utf8_to_utf16_decoder_top.sv
// UTF-8 to UTF-16 decoder, top level.
// Depends on utd_pkg, utd_front, utd_fifo and utd_back.
//
// Usage:
//   Input side is a queue write port: drive in_byte and in_string_end,
//   raise in_push; the beat is taken on a clock edge with in_full low.
//   Output side is a queue read port: while out_empty is low the oldest
//   result sits on out_code_unit, out_final_unit, out_invalid and
//   out_all_narrow; raise out_pop to take it.
//   A byte is validated in the cycle it is taken and its code point is
//   queued; the first result can be popped on the next cycle.
//   One byte is taken per cycle while in_full is low; a code point above
//   0xFFFF gives two result beats. Rate is set by the output port: one
//   result beat per cycle while out_empty is low and out_pop is high.
//   When the receiver stalls, up to DEPTH decoded entries wait in the
//   queue; then in_full rises and input beats hold off.
//   Synchronous reset clears the queue and the string state; no results
//   are pending after reset and the next byte starts a new string.
module utf8_to_utf16_decoder_top
  import utd_pkg::*;
#(
  parameter int DEPTH = UTD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  input  logic        in_string_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_code_unit,
  output logic        out_final_unit,
  output logic        out_invalid,
  output logic        out_all_narrow
);

  logic       accept;
  logic       wr_en;
  logic       rd_en;
  logic       q_empty;
  utd_entry_t wr_entry;
  utd_entry_t head;

  assign accept = in_push && !in_full;

  utd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .wr_en         (wr_en),
    .wr_entry      (wr_entry)
  );

  utd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (head),
    .full     (in_full),
    .empty    (q_empty)
  );

  utd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (!q_empty),
    .rd_en          (rd_en),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_code_unit  (out_code_unit),
    .out_final_unit (out_final_unit),
    .out_invalid    (out_invalid),
    .out_all_narrow (out_all_narrow)
  );

endmodule

FILE: verif/utf16_stream_checker.sv
`timescale 1ns / 1ps
// Result checker for the UTF-8 to UTF-16 decoder: watches both queue ports,
// decodes every accepted byte itself and compares each popped beat.
// Depends on utd_pkg for the decoder constants.
module utf16_stream_checker
  import utd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_byte,
  input  logic        in_string_end,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [15:0] out_code_unit,
  input  logic        out_final_unit,
  input  logic        out_invalid,
  input  logic        out_all_narrow,
  output int          fail_count,
  output int          pending_units
);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
    logic        invalid;
    logic        all_narrow;
  } utf16_beat_t;

  utf16_beat_t utf16_expected[$];
  utf16_beat_t head_beat;

  logic [1:0]  cont_left;
  logic [1:0]  seq_kind;
  logic [20:0] code_acc;
  logic        string_bad;
  logic        string_narrow;

  initial begin
    fail_count    = 0;
    pending_units = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("utf16 beat mismatch on %s: expected %0h, got %0h at %0t ns",
             what, want, got, $time);
    fail_count++;
  endtask

  task automatic queue_beat(input utf16_beat_t b);
    utf16_expected.insert(utf16_expected.size(), b);
  endtask

  task automatic clear_string();
    cont_left     = 2'd0;
    seq_kind      = UTD_SEQ_NONE;
    code_acc      = '0;
    string_bad    = 1'b0;
    string_narrow = 1'b1;
  endtask

  task automatic decode_utf8_byte(input logic [7:0] b, input logic last);
    logic [15:0] units [0:1];
    logic [20:0] cp;
    logic [20:0] min_cp;
    logic [20:0] offs;
    utf16_beat_t beat;
    int          n;
    logic        err;
    n   = 0;
    err = string_bad;
    if (!err) begin
      if (cont_left == 2'd0) begin
        if (b < UTD_ASCII_LIMIT) begin
          units[0] = {8'h00, b};
          n = 1;
        end else if ((b & 8'hE0) == 8'hC0) begin
          seq_kind  = UTD_SEQ_TWO;
          cont_left = 2'd1;
          code_acc  = {16'b0, b[4:0]};
        end else if ((b & 8'hF0) == 8'hE0) begin
          seq_kind  = UTD_SEQ_THREE;
          cont_left = 2'd2;
          code_acc  = {17'b0, b[3:0]};
        end else if ((b & 8'hF8) == 8'hF0) begin
          seq_kind  = UTD_SEQ_FOUR;
          cont_left = 2'd3;
          code_acc  = {18'b0, b[2:0]};
        end else begin
          err = 1'b1;
        end
      end else if ((b & 8'hC0) != 8'h80) begin
        err = 1'b1;
      end else begin
        code_acc  = {code_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          cp = code_acc;
          case (seq_kind)
            UTD_SEQ_TWO:   min_cp = UTD_MIN_2BYTE;
            UTD_SEQ_THREE: min_cp = UTD_MIN_3BYTE;
            default:       min_cp = UTD_MIN_4BYTE;
          endcase
          if (cp < min_cp || cp > UTD_MAX_CP ||
              (cp >= UTD_SURR_FIRST && cp <= UTD_SURR_LAST)) begin
            err = 1'b1;
          end else if (cp <= UTD_BMP_MAX) begin
            units[0] = cp[15:0];
            n = 1;
          end else begin
            offs     = cp - UTD_MIN_4BYTE;
            units[0] = UTD_HI_SURR_BASE + {6'b0, offs[19:10]};
            units[1] = UTD_LO_SURR_BASE + {6'b0, offs[9:0] & UTD_LO_MASK};
            n = 2;
          end
          seq_kind = UTD_SEQ_NONE;
          code_acc = '0;
        end
      end
      if (!err && last && cont_left != 2'd0) err = 1'b1;
    end

    if (err) begin
      if (last) begin
        beat = '{code_unit: 16'h0000, final_unit: 1'b1, invalid: 1'b1, all_narrow: 1'b0};
        queue_beat(beat);
        clear_string();
      end else begin
        string_bad = 1'b1;
        cont_left  = 2'd0;
        seq_kind   = UTD_SEQ_NONE;
        code_acc   = '0;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if ({5'b0, units[i]} > UTD_NARROW_MAX) string_narrow = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
        beat.code_unit  = units[i];
        beat.final_unit = last && (i == n - 1);
        beat.invalid    = 1'b0;
        beat.all_narrow = (last && (i == n - 1)) ? string_narrow : 1'b0;
        queue_beat(beat);
      end
      if (last) clear_string();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_string();
      utf16_expected.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (utf16_expected.size() == 0) begin
          report_mismatch("unexpected beat", 0, 32'(out_code_unit));
        end else begin
          head_beat = utf16_expected.pop_front();
          if (out_code_unit !== head_beat.code_unit)
            report_mismatch("code_unit", 32'(head_beat.code_unit), 32'(out_code_unit));
          if (out_final_unit !== head_beat.final_unit)
            report_mismatch("final_unit", 32'(head_beat.final_unit), 32'(out_final_unit));
          if (out_invalid !== head_beat.invalid)
            report_mismatch("invalid", 32'(head_beat.invalid), 32'(out_invalid));
          if (out_all_narrow !== head_beat.all_narrow)
            report_mismatch("all_narrow", 32'(head_beat.all_narrow), 32'(out_all_narrow));
        end
      end
      if (in_push && !in_full) decode_utf8_byte(in_byte, in_string_end);
    end
    pending_units <= utf16_expected.size();
  end

endmodule

FILE: verif/utf8_to_utf16_decoder_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the UTF-8 to UTF-16 decoder: drives directed and random
// UTF-8 strings under several idle patterns and gives the verdict.
// Depends on utd_pkg, utf8_to_utf16_decoder_top and utf16_stream_checker.
module utf8_to_utf16_decoder_top_tb
  import utd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 125;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {
    CORRUPT_REPLACE,
    CORRUPT_TRUNCATE,
    CORRUPT_INSERT,
    CORRUPT_OVERLONG,
    CORRUPT_RANGE
  } corrupt_kind_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_push        = 1'b0;
  logic        in_full;
  logic [7:0]  in_byte        = 8'h00;
  logic        in_string_end  = 1'b0;
  logic        out_empty;
  logic        out_pop        = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_final_unit;
  logic        out_invalid;
  logic        out_all_narrow;

  int fail_count;
  int pending_units;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int phase_sent;

  logic [7:0] utf8_bytes[$];

  utf8_to_utf16_decoder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_string_end  (in_string_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_code_unit  (out_code_unit),
    .out_final_unit (out_final_unit),
    .out_invalid    (out_invalid),
    .out_all_narrow (out_all_narrow)
  );

  utf16_stream_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_string_end  (in_string_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_code_unit  (out_code_unit),
    .out_final_unit (out_final_unit),
    .out_invalid    (out_invalid),
    .out_all_narrow (out_all_narrow),
    .fail_count     (fail_count),
    .pending_units  (pending_units)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_to_utf16_decoder_top_tb: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      in_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_byte       <= b;
    in_string_end <= last;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_string();
    for (int i = 0; i < utf8_bytes.size(); i++) begin
      send_byte(utf8_bytes[i], i == utf8_bytes.size() - 1);
    end
    phase_sent += utf8_bytes.size();
  endtask

  task automatic append_byte(input logic [7:0] b);
    utf8_bytes.insert(utf8_bytes.size(), b);
  endtask

  task automatic append_encoded(input logic [20:0] cp, input int len);
    case (len)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int utf8_length(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < UTD_MIN_3BYTE) return 2;
    if (cp < UTD_MIN_4BYTE) return 3;
    return 4;
  endfunction

  function automatic logic [20:0] random_code_point(input logic narrow_only);
    logic [20:0] cp;
    case ($urandom_range(narrow_only ? 1 : 5))
      0: cp = 21'($urandom_range(8'h7F));
      1: cp = 21'($urandom_range(8'h80, 8'hFF));
      2: cp = 21'($urandom_range(12'h100, 12'h7FF));
      3: begin
        cp = 21'($urandom_range(16'h0800, 16'hF7FF));
        if (cp >= UTD_SURR_FIRST) cp = cp + 21'h800;
      end
      4: cp = 21'($urandom_range(17'h10000, 21'h10FFFF));
      default: begin
        case ($urandom_range(8))
          0: cp = 21'h7F;
          1: cp = 21'h80;
          2: cp = 21'h7FF;
          3: cp = 21'h800;
          4: cp = 21'hD7FF;
          5: cp = 21'hE000;
          6: cp = UTD_BMP_MAX;
          7: cp = UTD_MIN_4BYTE;
          default: cp = UTD_MAX_CP;
        endcase
      end
    endcase
    return cp;
  endfunction

  task automatic build_random_string();
    corrupt_kind_t kind;
    logic          narrow_only;
    logic [20:0]   cp;
    int            n_cp;
    int            bad_at;
    int            len;
    utf8_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(255)));
      return;
    end
    narrow_only = ($urandom_range(3) == 0);
    n_cp        = $urandom_range(1, 5);
    bad_at      = ($urandom_range(4) == 0) ? $urandom_range(n_cp - 1) : -1;
    kind        = corrupt_kind_t'($urandom_range(CORRUPT_RANGE));
    for (int k = 0; k < n_cp; k++) begin
      if (k == bad_at && kind == CORRUPT_OVERLONG) begin
        len = $urandom_range(2, 4);
        case (len)
          2: cp = 21'($urandom_range(8'h7F));
          3: cp = 21'($urandom_range(12'h7FF));
          default: cp = 21'($urandom_range(16'hFFFF));
        endcase
        append_encoded(cp, len);
      end else if (k == bad_at && kind == CORRUPT_RANGE) begin
        if ($urandom_range(1) == 0)
          append_encoded(21'($urandom_range(UTD_SURR_FIRST, UTD_SURR_LAST)), 3);
        else
          append_encoded(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      end else begin
        cp = random_code_point(narrow_only);
        append_encoded(cp, utf8_length(cp));
      end
    end
    if (bad_at >= 0) begin
      case (kind)
        CORRUPT_REPLACE:
          utf8_bytes[$urandom_range(utf8_bytes.size() - 1)] = 8'($urandom_range(255));
        CORRUPT_TRUNCATE:
          utf8_bytes.delete(utf8_bytes.size() - 1);
        CORRUPT_INSERT:
          utf8_bytes.insert($urandom_range(utf8_bytes.size()), 8'($urandom_range(255)));
        default: ;
      endcase
    end
    if (utf8_bytes.size() == 0) append_byte(8'($urandom_range(8'h7F)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    utf8_bytes = '{8'h00, 8'h7F};
    send_string();
    utf8_bytes = '{8'hC2, 8'h80, 8'hDF, 8'hBF};
    send_string();
    utf8_bytes = '{8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    utf8_bytes = '{8'hC0, 8'h80};
    send_string();
    utf8_bytes = '{8'hED, 8'hA0, 8'h80};
    send_string();
    utf8_bytes = '{8'hF5, 8'h80, 8'h80, 8'h80};
    send_string();
    utf8_bytes = '{8'h80, 8'h41};
    send_string();
    utf8_bytes = '{8'hC3, 8'h41};
    send_string();
    utf8_bytes = '{8'hE2, 8'h82};
    send_string();
    utf8_bytes = '{8'hFF};
    send_string();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 69; end
        default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        build_random_string();
        send_string();
      end
    end

    in_push        <= 1'b0;
    recv_stall_pct <= 0;
    @(posedge clk);
    while (pending_units != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_units == 0) begin
      $display("utf8_to_utf16_decoder_top_tb: PASS");
    end else begin
      $display("utf8_to_utf16_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/utd_pkg.sv
rtl/utd_front.sv
rtl/utd_fifo.sv
rtl/utd_back.sv
rtl/utf8_to_utf16_decoder_top.sv
verif/utf16_stream_checker.sv
verif/utf8_to_utf16_decoder_top_tb.sv
